// ===== design/sha1_pkg.sv =====
// constants and types for the sha-1 message hasher
package sha1_pkg;
  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_END = 1'b1;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  typedef logic [31:0] word_t;
endpackage

// ===== design/sha1_message_hasher.sv =====
// sha-1 hasher over a byte stream with one shared round unit
// an append beat writes one byte; when it completes a 64-byte block it starts a compression (S_COMP, then S_ADD)
// an end beat runs the padding one byte per cycle plus one or two compressions
// then offers five digest beats; compression is one round per cycle in a shared round unit
// no input byte is accepted while a block is compressed, so long messages are bound by the round unit
// reset (rst_n low, synchronous) loads the initial chaining words and clears the bit count
module sha1_message_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word[31:0]
  output logic        out_tlast   // digest_last
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_COMP, S_ADD, S_PAD, S_OUT} state_t;

  state_t      state_r;
  word_t       h_r [5];
  word_t       w_r [16];
  word_t       a_r, b_r, c_r, d_r, e_r;
  logic [63:0] cnt_r;
  logic [63:0] len_r;
  logic [6:0]  rnd_r;
  logic        fin_r;     // end seen: padding, compression or digest output in progress
  logic [2:0]  oidx_r;
  logic [7:0]  pbyte;
  logic [5:0]  pos;
  logic [1:0]  bsel;
  logic [3:0]  widx;
  logic [6:0]  pad_dist;  // padding bytes written so far
  word_t       wt, f, k, tmp, wx;
  logic [7:0]  absorb_byte;
  logic        do_absorb;

  assign pos  = cnt_r[8:3];
  assign widx = pos[5:2];
  assign bsel = pos[1:0];
  assign pad_dist = cnt_r[9:3] - len_r[9:3];

  always_comb begin
    if (pos >= LEN_POS && pad_dist > {1'b0, pos - LEN_POS})
      pbyte = len_r[8'(63 - 8 * (pos - LEN_POS)) -: 8];
    else if (cnt_r[8:3] == len_r[8:3] && cnt_r == len_r) pbyte = PAD_BYTE;
    else pbyte = 8'h00;
  end

  assign wx = {w_r[0][31:0]} ^ w_r[2] ^ w_r[8] ^ w_r[13];
  always_comb begin
    wt = (rnd_r < 7'd16) ? w_r[0] : {wx[30:0], wx[31]};
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r; k = K3;
    end
    tmp = {a_r[26:0], a_r[31:27]} + f + e_r + k + wt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = h_r[oidx_r];
  assign out_tlast  = (oidx_r == 3'd4);

  assign do_absorb   = (state_r == S_IDLE && in_tvalid && in_tuser == OP_APPEND)
                       || state_r == S_PAD;
  assign absorb_byte = (state_r == S_PAD) ? pbyte : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      h_r <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
      cnt_r <= '0;
      len_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      oidx_r <= '0;
    end else begin
      if (do_absorb) begin
        w_r[widx][8'(31 - 8 * bsel) -: 8] <= absorb_byte;
        cnt_r <= cnt_r + 64'd8;
        if (pos == 6'd63) begin
          state_r <= S_COMP;
          rnd_r <= '0;
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
        end
      end
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tuser == OP_END) begin
          len_r <= cnt_r;
          fin_r <= 1'b1;
          state_r <= S_PAD;
        end
        S_PAD: ;
        S_COMP: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
          w_r[15] <= wt;
          e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]}; b_r <= a_r; a_r <= tmp;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'd79) state_r <= S_ADD;
        end
        S_ADD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
          if (!fin_r) state_r <= S_IDLE;
          else if (pad_dist > 7'd8) begin
            state_r <= S_OUT;
            oidx_r <= '0;
          end else state_r <= S_PAD;
        end
        S_OUT: if (out_tready) begin
          if (oidx_r == 3'd4) begin
            oidx_r <= '0;
            state_r <= S_IDLE;
            fin_r <= 1'b0;
            cnt_r <= '0;
            h_r <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
          end else oidx_r <= oidx_r + 3'd1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> oidx_r <= 3'd4) else $error("digest index out of range");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMP |-> !in_tready) else $error("ready while compressing");
  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |-> rnd_r == 7'd80) else $error("round count wrong at add");
  a_out_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> fin_r) else $error("digest without end");
endmodule

// ===== tb/sha1_message_hasher_checker.sv =====
// digest predictor and output checker for the sha-1 message hasher
`timescale 1ns / 100ps
module sha1_message_hasher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // opcode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // digest_word[31:0]
  input  logic        out_tlast,  // digest_last
  output int          mismatch_count,
  output int          digests_pending,
  output int          digest_words_seen
);
  import sha1_pkg::*;

  typedef struct packed {
    word_t word;
    logic  last;
  } digest_beat_t;

  word_t        chain [5];
  word_t        msg_block [16];
  logic [63:0]  msg_bits;
  digest_beat_t digest_fifo [$];

  function automatic word_t rol(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress_block();
    word_t w [16];
    word_t a, b, c, d, e, f, k, wt, tmp;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = rol(w[(t + 13) & 15] ^ w[(t + 8) & 15] ^ w[(t + 2) & 15] ^ w[t & 15], 1);
        w[t & 15] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      tmp = rol(a, 5) + f + e + k + wt;
      e = d; d = c; c = rol(b, 30); b = a; a = tmp;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic absorb_byte(logic [7:0] data);
    logic [5:0] pos;
    pos = msg_bits[8:3];
    msg_block[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = data;
    msg_bits += 64'd8;
    if (pos == 6'd63) compress_block();
  endtask

  task automatic reset_chain();
    chain[0] = H0_INIT; chain[1] = H1_INIT; chain[2] = H2_INIT;
    chain[3] = H3_INIT; chain[4] = H4_INIT;
    msg_bits = '0;
  endtask

  task automatic finish_message();
    logic [63:0] len;
    len = msg_bits;
    absorb_byte(PAD_BYTE);
    while (msg_bits[8:3] != LEN_POS) absorb_byte(8'h00);
    for (int i = 7; i >= 0; i--) absorb_byte(len[i * 8 +: 8]);
    for (int i = 0; i < 5; i++) digest_fifo.push_back('{chain[i], i == 4});
    reset_chain();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_chain();
      digest_fifo.delete();
      mismatch_count = 0;
      digest_words_seen = 0;
      digests_pending = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_END) finish_message();
        else absorb_byte(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        digest_beat_t exp_beat;
        digest_words_seen++;
        if (digest_fifo.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected digest beat: word %h last %b", out_tdata, out_tlast);
        end else begin
          exp_beat = digest_fifo.pop_front();
          if (exp_beat.word !== out_tdata || exp_beat.last !== out_tlast) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("digest mismatch: expected %h last %b, got %h last %b",
                       exp_beat.word, exp_beat.last, out_tdata, out_tlast);
          end
        end
      end
      digests_pending = digest_fifo.size();
    end
  end
endmodule

// ===== tb/sha1_message_hasher_tb.sv =====
// stimulus and verdict for the sha-1 message hasher
`timescale 1ns / 100ps
module sha1_message_hasher_tb;
  import sha1_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // data_byte[7:0]
  logic        in_tuser;   // opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // digest_word[31:0]
  logic        out_tlast;  // digest_last
  int          mismatch_count;
  int          digests_pending;
  int          digest_words_seen;
  int          beats_sent;
  int          messages_sent;
  int          idle_cycles;
  bit          send_fast;
  bit          recv_fast;
  bit          hold_out;

  sha1_message_hasher DUT (.*);

  sha1_message_hasher_checker checker_i (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_beat(logic op, logic [7:0] data);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, 18);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (op == OP_END) messages_sent++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_beat(OP_APPEND, 8'($urandom));
    send_beat(OP_END, 8'($urandom));
  endtask

  // receiver
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end else if (!recv_fast && $urandom_range(0, 1)) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (!(out_tvalid && out_tready)) begin
        while (!out_tvalid) @(posedge clk);
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n) idle_cycles <= 0;
    else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int len;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_APPEND;
    beats_sent  = 0;
    messages_sent = 0;
    send_fast   = 1'b0;
    recv_fast   = 1'b0;
    hold_out    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, unused byte on end, "abc", byte extremes
    send_beat(OP_END, 8'h00);
    send_beat(OP_END, 8'hFF);
    send_beat(OP_APPEND, 8'h61);
    send_beat(OP_APPEND, 8'h62);
    send_beat(OP_APPEND, 8'h63);
    send_beat(OP_END, 8'h00);
    send_beat(OP_APPEND, 8'h00);
    send_beat(OP_APPEND, 8'hFF);
    send_beat(OP_END, 8'hA5);

    // sender waits for all digests
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (digests_pending != 0) @(posedge clk);

    // receiver holds off while the sender keeps going
    hold_out  = 1'b1;
    send_fast = 1'b1;
    for (int i = 0; i < 4; i++) send_message($urandom_range(0, 4));
    send_fast = 1'b0;

    while (beats_sent < 360) begin
      send_fast = ($urandom_range(0, 3) == 0);
      recv_fast = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(55, 56);
        2: len = $urandom_range(63, 64);
        3: len = $urandom_range(119, 128);
        default: len = $urandom_range(0, 30);
      endcase
      if (beats_sent + len + 1 > 360) len = 360 - beats_sent - 1;
      send_message(len);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (digests_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d messages in %0d input beats, %0d digest words compared",
             messages_sent, beats_sent, digest_words_seen);
    $display("including padding edges near 56 and 64 bytes and a long output stall");
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
